/* rtl/rrdf_pkg.sv */
// Package for the route request duplicate filter.
// Holds table sizing, record layout, mode codes and inter-module structs.
// No dependencies.
`timescale 1ns / 1ps

package rrdf_pkg;

    // Ring size and derived widths
    localparam int TABLE_DEPTH = 1024;
    localparam int ADDR_W      = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

    typedef logic [ADDR_W-1:0] t_addr;
    typedef logic [CNT_W-1:0]  t_cnt;

    // Request mode codes
    localparam logic MODE_CHECK  = 1'b0;
    localparam logic MODE_RECORD = 1'b1;

    // One stored record: source, destination, request id
    typedef struct packed {
        logic [31:0] src_addr;
        logic [31:0] dst_addr;
        logic [31:0] request_id;
    } t_record;

    localparam int RECORD_W = $bits(t_record);

    // Request handed to the sequencer, source already resolved
    typedef struct packed {
        logic    mode;
        t_record rec;
    } t_key;

    // Table RAM access from the sequencer
    typedef struct packed {
        logic    we;
        t_addr   waddr;
        t_record wdata;
        logic    re;
        t_addr   raddr;
    } t_ram_req;

    // Status back to the top level
    typedef struct packed {
        logic busy;
        logic done;
        logic is_duplicate;
    } t_status;

endpackage

/* rtl/rrdf_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module rrdf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                        i_clk,
    input  logic                                        i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                            i_wdata,
    input  logic                                        i_re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                            o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read port
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

/* rtl/rrdf_seq.sv */
// Scan/insert sequencer with the shared record comparator.
// Depends on rrdf_pkg; drives the table RAM through a t_ram_req struct.
`timescale 1ns / 1ps

module rrdf_seq (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  rrdf_pkg::t_key    i_key,
    input  rrdf_pkg::t_record i_rdata,
    output rrdf_pkg::t_ram_req o_ram,
    output rrdf_pkg::t_status o_status
);

    import rrdf_pkg::*;

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_SCAN  = 2'd1;
    localparam logic [1:0] S_WRITE = 2'd2;

    logic [1:0] r_state, n_state;
    t_key       r_key,   n_key;
    t_addr      r_addr,  n_addr;    // next slot to read
    logic       r_issue, n_issue;   // reads still to issue
    logic       r_pend,  n_pend;    // read data arrives this cycle
    t_addr      r_wptr,  n_wptr;    // ring write pointer
    t_cnt       r_fill,  n_fill;    // slots below this are valid
    logic       r_done,  n_done;
    logic       r_dup,   n_dup;

    t_ram_req   ram;
    logic       hit;

    // Shared comparator on the registered read data
    assign hit = (i_rdata == r_key.rec);

    // Sequencer
    always_comb begin
        n_state = r_state;
        n_key   = r_key;
        n_addr  = r_addr;
        n_issue = r_issue;
        n_pend  = 1'b0;
        n_wptr  = r_wptr;
        n_fill  = r_fill;
        n_done  = 1'b0;
        n_dup   = r_dup;

        ram.we    = 1'b0;
        ram.waddr = r_wptr;
        ram.wdata = r_key.rec;
        ram.re    = 1'b0;
        ram.raddr = r_addr;

        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    n_key   = i_key;
                    n_addr  = '0;
                    n_issue = 1'b1;
                    if (i_key.mode == MODE_RECORD || r_fill == '0) begin
                        n_state = S_WRITE;
                    end else begin
                        n_state = S_SCAN;
                    end
                end
            end
            S_SCAN: begin
                // issue one read per cycle over the valid slots
                if (r_issue) begin
                    ram.re = 1'b1;
                    if (t_cnt'(r_addr) + t_cnt'(1) == r_fill) begin
                        n_issue = 1'b0;
                    end else begin
                        n_addr = r_addr + t_addr'(1);
                    end
                end
                n_pend = r_issue;
                // compare the slot read last cycle
                if (r_pend && hit) begin
                    n_done  = 1'b1;
                    n_dup   = 1'b1;
                    n_pend  = 1'b0;
                    n_state = S_IDLE;
                end else if (!r_issue && !r_pend) begin
                    n_state = S_WRITE;
                end
            end
            S_WRITE: begin
                ram.we = 1'b1;
                if (r_wptr == t_addr'(TABLE_DEPTH - 1)) begin
                    n_wptr = '0;
                end else begin
                    n_wptr = r_wptr + t_addr'(1);
                end
                if (r_fill != t_cnt'(TABLE_DEPTH)) begin
                    n_fill = r_fill + t_cnt'(1);
                end
                n_done  = 1'b1;
                n_dup   = 1'b0;
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_issue <= 1'b0;
            r_pend  <= 1'b0;
            r_wptr  <= '0;
            r_fill  <= '0;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_issue <= n_issue;
            r_pend  <= n_pend;
            r_wptr  <= n_wptr;
            r_fill  <= n_fill;
            r_done  <= n_done;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_key  <= n_key;
        r_addr <= n_addr;
        r_dup  <= n_dup;
    end

    assign o_ram                 = ram;
    assign o_status.busy         = (r_state != S_IDLE);
    assign o_status.done         = r_done;
    assign o_status.is_duplicate = r_dup;

    // Checks
    a_done_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |=> !r_done)
        else $error("result strobe held for two cycles");

    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= t_cnt'(TABLE_DEPTH))
        else $error("fill count beyond table depth");

    a_write_new: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ram.we |=> (r_done && !r_dup))
        else $error("insert not reported as new");

    a_dup_check_only: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_done && r_dup) |-> (r_key.mode == MODE_CHECK))
        else $error("duplicate reported for own request");

    a_read_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ram.re |-> (t_cnt'(ram.raddr) < r_fill))
        else $error("read of a slot never written");

endmodule

/* rtl/route_request_duplicate_filter_top.sv */
// Top level of the route request duplicate filter.
// Depends on rrdf_pkg, rrdf_seq and rrdf_ram.
//
// A request is transferred when start is high and busy is low. In check mode
// it is compared with every stored record, one table slot per cycle through a
// single comparator fed by the table RAM; only slots written since reset
// (tracked by a fill count, no clearing pass) are read. The scan ends at the
// first match; the number of filled slots is up to 1024. Record mode and
// a check on an empty table go straight to the insert. The result shows on
// o_is_duplicate while o_done is high for exactly one cycle and cannot be
// stalled; busy is low in that cycle, so a new request may be transferred
// then. host_addr is written through i_cfg_we / i_cfg_wdata; the user must
// write it only while idle, the block itself does not enforce this.
`timescale 1ns / 1ps

module route_request_duplicate_filter_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [31:0] i_cfg_wdata,
    input  logic        start,
    output logic        busy,
    input  logic        i_mode,
    input  logic [31:0] i_src_addr,
    input  logic [31:0] i_dst_addr,
    input  logic [31:0] i_request_id,
    output logic        o_done,
    output logic        o_is_duplicate
);

    import rrdf_pkg::*;

    logic [31:0] r_host_addr;
    t_key        key;
    t_ram_req    ram;
    t_status     status;
    logic [RECORD_W-1:0] rdata_raw;

    // Host address register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_host_addr <= '0;
        end else if (i_cfg_we) begin
            r_host_addr <= i_cfg_wdata;
        end
    end

    // Own requests take the host address as source
    always_comb begin
        key.mode           = i_mode;
        key.rec.src_addr   = (i_mode == MODE_RECORD) ? r_host_addr : i_src_addr;
        key.rec.dst_addr   = i_dst_addr;
        key.rec.request_id = i_request_id;
    end

    rrdf_seq u_seq (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (start),
        .i_key    (key),
        .i_rdata  (t_record'(rdata_raw)),
        .o_ram    (ram),
        .o_status (status)
    );

    // Record table
    rrdf_ram #(
        .WIDTH (RECORD_W),
        .DEPTH (TABLE_DEPTH)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (ram.we),
        .i_waddr (ram.waddr),
        .i_wdata (ram.wdata),
        .i_re    (ram.re),
        .i_raddr (ram.raddr),
        .o_rdata (rdata_raw)
    );

    assign busy           = status.busy;
    assign o_done         = status.done;
    assign o_is_duplicate = status.is_duplicate;

endmodule
